### hdl/priority_tick_scheduler_top_macros.svh
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PRIORITY_TICK_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_TICK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pts_pkg.sv
// Types and codes of the priority tick scheduler.
// No dependencies; used by pts_alu, the top level and the checker.
package pts_pkg;

	localparam logic [2:0] CMD_SCHED  = 3'd0;
	localparam logic [2:0] CMD_CHARGE = 3'd1;
	localparam logic [2:0] CMD_PRIO   = 3'd2;
	localparam logic [2:0] CMD_BLOCK  = 3'd3;
	localparam logic [2:0] CMD_SLEEP  = 3'd4;

	localparam int ST_BLOCKED_BIT  = 0;
	localparam int ST_SLEEPING_BIT = 1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  target_pid;
		logic [31:0] amount;
		logic        blocked_value;
		logic        nested_pass;
	} item_t;

	typedef struct packed {
		logic [3:0] running_pid;
		logic       picked;
		logic       reloaded;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RELOAD,
		ST_ONE,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_SCAN,
		OP_RELOAD,
		OP_CHARGE,
		OP_PRIO,
		OP_BLOCK,
		OP_SLEEP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        bval;
		logic [31:0] amount;
	} alu_ctl_t;

	function automatic op_t cmd_to_op(input logic [2:0] cmd);
		op_t op;
		case (cmd)
			CMD_CHARGE: op = OP_CHARGE;
			CMD_PRIO:   op = OP_PRIO;
			CMD_BLOCK:  op = OP_BLOCK;
			CMD_SLEEP:  op = OP_SLEEP;
			default:    op = OP_SCAN;
		endcase
		return op;
	endfunction

endpackage

### hdl/pts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/pts_alu.sv
// Shared row-update unit: one comparator and one 32-bit decrementer.
// Depends on pts_pkg for the operation codes and control struct.
module pts_alu #(
	parameter int SLICE_BITS = 16
) (
	input  pts_pkg::alu_ctl_t          ctl,
	input  logic [2*SLICE_BITS+33:0]   row_in,
	input  logic [SLICE_BITS-1:0]      best,
	output logic [2*SLICE_BITS+33:0]   row_out,
	output logic                       better
);

	localparam int S = SLICE_BITS;

	logic [S-1:0]  slice;
	logic [S-1:0]  reload;
	logic [31:0]   sleep;
	logic [1:0]    status;
	logic [S-1:0]  slice_n;
	logic [S-1:0]  reload_n;
	logic [31:0]   sleep_n;
	logic [1:0]    status_n;
	logic [31:0]   dec_in;
	logic [31:0]   dec_out;
	logic          ready;

	assign slice  = row_in[S-1:0];
	assign reload = row_in[2*S-1:S];
	assign sleep  = row_in[2*S+31:2*S];
	assign status = row_in[2*S+33:2*S+32];

	// one decrementer serves both the slice charge and the sleep countdown
	assign dec_in  = (ctl.op == pts_pkg::OP_CHARGE) ? 32'(slice) : sleep;
	assign dec_out = dec_in - 32'd1;

	assign ready  = (status == 2'b00);
	assign better = ready && (slice > best);

	always_comb begin
		slice_n  = slice;
		reload_n = reload;
		sleep_n  = sleep;
		status_n = status;
		case (ctl.op)
			pts_pkg::OP_SCAN: begin
				if (status[pts_pkg::ST_SLEEPING_BIT]) begin
					if (sleep == 32'd0) begin
						status_n[pts_pkg::ST_SLEEPING_BIT] = 1'b0;
					end else begin
						sleep_n = dec_out;
					end
				end
			end
			pts_pkg::OP_RELOAD: begin
				slice_n = reload;
			end
			pts_pkg::OP_CHARGE: begin
				if (slice != '0) begin
					slice_n = dec_out[S-1:0];
				end
			end
			pts_pkg::OP_PRIO: begin
				reload_n = ctl.amount[S-1:0];
			end
			pts_pkg::OP_BLOCK: begin
				status_n[pts_pkg::ST_BLOCKED_BIT] = ctl.bval;
			end
			pts_pkg::OP_SLEEP: begin
				status_n[pts_pkg::ST_SLEEPING_BIT] = 1'b1;
				sleep_n = ctl.amount;
			end
			default: begin
			end
		endcase
	end

	assign row_out = {status_n, sleep_n, reload_n, slice_n};

endmodule

### hdl/priority_tick_scheduler_top.sv
// Priority tick scheduler: sequencer, process table RAM and shared row unit.
// Depends on pts_pkg, pts_ram and pts_alu.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------
//   command | start, accepted when !busy | item   (pts_pkg::item_t)
//   result  | done, one-cycle strobe     | result (pts_pkg::result_t)
//
// A schedule pass sweeps every row through the single-read-port RAM, and sweeps
// them again when the slices reload; every other command reads and writes one
// row; an unknown or out-of-range command touches no row.
// Reset leaves every row invalid (reading as zero) and running index zero.
// done is high for exactly one cycle per transaction; the receiver never stalls.
module priority_tick_scheduler_top #(
	parameter int NUM_PROCS  = 16,
	parameter int SLICE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pts_pkg::item_t   item,
	output logic             done,
	output pts_pkg::result_t result
);

	localparam int PID_W = $clog2(NUM_PROCS);
	localparam int ROW_W = 2 * SLICE_BITS + 34;
	localparam logic [PID_W-1:0] LAST_IDX = PID_W'(NUM_PROCS - 1);

	pts_pkg::state_t         state_q, state_d;
	logic [PID_W-1:0]        idx_q, idx_d;
	pts_pkg::item_t          item_q;
	logic [NUM_PROCS-1:0]    valid_q;
	logic [SLICE_BITS-1:0]   best_q, best_d;
	logic [PID_W-1:0]        run_q, run_d;
	logic                    done_q, done_d;
	pts_pkg::result_t        res_q, res_d;

	logic                    rd_issue;
	logic [PID_W-1:0]        rd_addr;
	pts_pkg::op_t            rd_op;

	logic                    vld_s1;
	logic                    row_ok_s1;
	logic [PID_W-1:0]        addr_s1;
	pts_pkg::op_t            op_s1;

	logic [ROW_W-1:0]        rdata;
	logic [ROW_W-1:0]        row_in;
	logic [ROW_W-1:0]        row_out;
	logic                    better;
	pts_pkg::alu_ctl_t       alu_ctl;
	logic                    in_range;

	assign busy   = (state_q != pts_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign in_range = (32'(item.target_pid) < NUM_PROCS);

	// never-written rows read as their reset value
	assign row_in = row_ok_s1 ? rdata : '0;

	assign alu_ctl.op     = op_s1;
	assign alu_ctl.bval   = item_q.blocked_value;
	assign alu_ctl.amount = item_q.amount;

	pts_alu #(
		.SLICE_BITS(SLICE_BITS)
	) u_alu (
		.ctl    (alu_ctl),
		.row_in (row_in),
		.best   (best_q),
		.row_out(row_out),
		.better (better)
	);

	pts_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_PROCS)
	) u_table (
		.clk  (clk),
		.we   (vld_s1),
		.waddr(addr_s1),
		.wdata(row_out),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		best_d   = best_q;
		run_d    = run_q;
		done_d   = 1'b0;
		res_d    = res_q;
		rd_issue = 1'b0;
		rd_addr  = idx_q;
		rd_op    = pts_pkg::OP_SCAN;

		// track the highest ready slice as rows stream by; on a tie the earlier row wins
		if (vld_s1 && (op_s1 == pts_pkg::OP_SCAN) && better) begin
			best_d = row_in[SLICE_BITS-1:0];
			if (!item_q.nested_pass) begin
				run_d = addr_s1;
			end
		end

		case (state_q)
			pts_pkg::ST_IDLE: begin
				if (start) begin
					idx_d  = '0;
					best_d = '0;
					if (item.cmd == pts_pkg::CMD_SCHED) begin
						state_d = pts_pkg::ST_SCAN;
					end else if ((item.cmd == pts_pkg::CMD_CHARGE) ||
						((item.cmd inside {pts_pkg::CMD_PRIO, pts_pkg::CMD_BLOCK,
						pts_pkg::CMD_SLEEP}) && in_range)) begin
						state_d = pts_pkg::ST_ONE;
					end else begin
						state_d = pts_pkg::ST_FINISH;
					end
				end
			end
			pts_pkg::ST_SCAN: begin
				rd_issue = 1'b1;
				rd_op    = pts_pkg::OP_SCAN;
				if (idx_q == LAST_IDX) begin
					idx_d   = '0;
					state_d = pts_pkg::ST_DECIDE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			pts_pkg::ST_DECIDE: begin
				// last row is being written now; best_d is final
				if (best_d == '0) begin
					state_d = pts_pkg::ST_RELOAD;
				end else begin
					state_d = pts_pkg::ST_FINISH;
				end
			end
			pts_pkg::ST_RELOAD: begin
				rd_issue = 1'b1;
				rd_op    = pts_pkg::OP_RELOAD;
				if (idx_q == LAST_IDX) begin
					idx_d   = '0;
					state_d = pts_pkg::ST_FINISH;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			pts_pkg::ST_ONE: begin
				rd_issue = 1'b1;
				rd_op    = pts_pkg::cmd_to_op(item_q.cmd);
				rd_addr  = (item_q.cmd == pts_pkg::CMD_CHARGE) ? run_q :
					PID_W'(item_q.target_pid);
				state_d  = pts_pkg::ST_FINISH;
			end
			pts_pkg::ST_FINISH: begin
				done_d            = 1'b1;
				res_d.running_pid = 4'(run_q);
				res_d.picked      = (item_q.cmd == pts_pkg::CMD_SCHED) && (best_q != '0);
				res_d.reloaded    = (item_q.cmd == pts_pkg::CMD_SCHED) && (best_q == '0);
				state_d           = pts_pkg::ST_IDLE;
			end
			default: begin
				state_d = pts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_IDLE;
			idx_q   <= '0;
			best_q  <= '0;
			run_q   <= '0;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			best_q  <= best_d;
			run_q   <= run_d;
			done_q  <= done_d;
			vld_s1  <= rd_issue;
			if (vld_s1) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		row_ok_s1 <= valid_q[rd_addr];
		addr_s1   <= rd_addr;
		op_s1     <= rd_op;
		res_q     <= res_d;
	end

endmodule

### hdl/pts_checker.sv
// Port-level checker for the priority tick scheduler, bound to the top level.
// Depends on pts_pkg and priority_tick_scheduler_top_macros.svh.
`include "priority_tick_scheduler_top_macros.svh"

module pts_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input pts_pkg::result_t result
);

	`PTS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")
	`PTS_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held longer than one cycle")
	`PTS_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy), "result without a transaction in progress")
	`PTS_ASSERT_IMP(a_pick_or_reload, clk, arst_n, done, !(result.picked && result.reloaded), "pass reported both a pick and a reload")

endmodule

bind priority_tick_scheduler_top pts_checker u_pts_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
